// ----- sv/dpf_pkg.sv -----
package dpf_pkg;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    localparam logic [7:0] START_BYTE   = 8'h02;
    localparam logic [7:0] VERSION_BYTE = 8'h31;
    localparam logic [15:0] LENGTH_BIAS = 16'd8;

    localparam int POS_W = 5;
    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t POS_START    = 5'd0;
    localparam pos_t POS_SUB1     = 5'd1;
    localparam pos_t POS_SUB2     = 5'd2;
    localparam pos_t POS_VERSION  = 5'd3;
    localparam pos_t POS_LEN_LAST = 5'd7;
    localparam pos_t POS_TOT_LAST = 5'd11;
    localparam pos_t POS_NUM_LAST = 5'd15;
    localparam pos_t POS_CSUM_HI  = 5'd16;
    localparam pos_t POS_CSUM_LO  = 5'd17;
    localparam pos_t POS_DATA     = 5'd18;
    localparam pos_t POS_DATA_OFS = 5'd15;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10)
        begin
            r = 8'h30 + {4'h0, v};
        end
        else
        begin
            r = 8'h37 + {4'h0, v};
        end
        return r;
    endfunction

    function automatic logic is_hex_char(input logic [7:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h46));
    endfunction

endpackage

// ----- sv/data_packet_framer.sv -----
// Channel | Handshake              | Payload
// input   | in_valid / in_stall    | kind, subtype_first, subtype_second, packet_total,
//         |                        | packet_number, data_length, data_byte
// output  | out_valid / out_stall  | out_byte, run_last, frame_end
//
// Unstalled, one byte leaves the output register per cycle; the output register sets the rate.
// A header gives 16 bytes, or 18 when its length is zero; a data byte gives 1 byte,
// or 3 when it closes the packet; a data byte with no packet open is dropped unsent.
// An accepted transaction is held in the item register; its bytes show via the output register.
// rst_n clears the item and output valid flags and the packet state at once.
// The next transaction is taken in the cycle in which the current one hands over its last byte.
module data_packet_framer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  subtype_first,
    input  logic [7:0]  subtype_second,
    input  logic [15:0] packet_total,
    input  logic [15:0] packet_number,
    input  logic [15:0] data_length,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        frame_end
);

    import dpf_pkg::*;

    logic        item_valid_reg;
    logic        item_valid_next;
    logic        kind_reg;
    logic [7:0]  sub1_reg;
    logic [7:0]  sub2_reg;
    logic [15:0] total_reg;
    logic [15:0] number_reg;
    logic [15:0] length_reg;
    logic [7:0]  data_reg;
    pos_t        idx_reg;
    pos_t        idx_next;

    logic [15:0] remaining_reg;
    logic [15:0] remaining_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic        open_reg;
    logic        open_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        run_last_reg;
    logic        frame_end_reg;

    pos_t        pos;
    logic [15:0] hex_src;
    logic [3:0]  nibble;
    logic [7:0]  csum;
    logic [7:0]  byte_val;
    logic        is_last;
    logic        drop;
    logic        can_load;
    logic        emit;
    logic        consume;
    logic        accept;

    always_comb
    begin
        if (kind_reg == KIND_HEADER)
        begin
            pos = idx_reg;
        end
        else if (idx_reg == POS_START)
        begin
            pos = POS_DATA;
        end
        else
        begin
            pos = idx_reg + POS_DATA_OFS;
        end

        if (pos <= POS_LEN_LAST)
        begin
            hex_src = length_reg + LENGTH_BIAS;
        end
        else if (pos <= POS_TOT_LAST)
        begin
            hex_src = total_reg;
        end
        else
        begin
            hex_src = number_reg;
        end

        case (pos[1:0])
            2'd0:    nibble = hex_src[15:12];
            2'd1:    nibble = hex_src[11:8];
            2'd2:    nibble = hex_src[7:4];
            default: nibble = hex_src[3:0];
        endcase

        csum = 8'h00 - sum_reg;

        case (pos)
            POS_START:   byte_val = START_BYTE;
            POS_SUB1:    byte_val = sub1_reg;
            POS_SUB2:    byte_val = sub2_reg;
            POS_VERSION: byte_val = VERSION_BYTE;
            POS_CSUM_HI: byte_val = hex_digit(csum[7:4]);
            POS_CSUM_LO: byte_val = hex_digit(csum[3:0]);
            POS_DATA:    byte_val = data_reg;
            default:     byte_val = hex_digit(nibble);
        endcase

        is_last = (pos == POS_CSUM_LO)
               || ((pos == POS_NUM_LAST) && (length_reg != 16'd0))
               || ((pos == POS_DATA) && (remaining_reg != 16'd1));

        drop     = item_valid_reg && (kind_reg == KIND_DATA) && (idx_reg == POS_START)
                && !open_reg;
        can_load = !out_valid_reg || !out_stall;
        emit     = item_valid_reg && !drop && can_load;
        consume  = drop || (emit && is_last);
        in_stall = item_valid_reg && !consume;
        accept   = in_valid && !in_stall;

        item_valid_next = accept || (item_valid_reg && !consume);
        if (accept)
        begin
            idx_next = POS_START;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 5'd1;
        end
        else
        begin
            idx_next = idx_reg;
        end

        sum_next       = sum_reg;
        remaining_next = remaining_reg;
        open_next      = open_reg;
        if (emit)
        begin
            case (pos)
                POS_START:
                begin
                    sum_next = 8'h00;
                end
                POS_CSUM_HI:
                begin
                    sum_next = sum_reg;
                end
                POS_CSUM_LO:
                begin
                    open_next      = 1'b0;
                    remaining_next = 16'd0;
                end
                POS_DATA:
                begin
                    sum_next       = sum_reg + byte_val;
                    remaining_next = remaining_reg - 16'd1;
                end
                POS_NUM_LAST:
                begin
                    sum_next       = sum_reg + byte_val;
                    remaining_next = length_reg;
                    open_next      = 1'b1;
                end
                default:
                begin
                    sum_next = sum_reg + byte_val;
                end
            endcase
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            idx_reg        <= POS_START;
            remaining_reg  <= 16'd0;
            sum_reg        <= 8'h00;
            open_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            idx_reg        <= idx_next;
            remaining_reg  <= remaining_next;
            sum_reg        <= sum_next;
            open_reg       <= open_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind;
            sub1_reg   <= subtype_first;
            sub2_reg   <= subtype_second;
            total_reg  <= packet_total;
            number_reg <= packet_number;
            length_reg <= data_length;
            data_reg   <= data_byte;
        end
        if (emit)
        begin
            out_byte_reg  <= byte_val;
            run_last_reg  <= is_last;
            frame_end_reg <= (pos == POS_CSUM_LO);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign frame_end = frame_end_reg;

endmodule

// ----- sv/dpf_checker.sv -----
module dpf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        kind,
    input logic [7:0]  subtype_first,
    input logic [7:0]  subtype_second,
    input logic [15:0] packet_total,
    input logic [15:0] packet_number,
    input logic [15:0] data_length,
    input logic [7:0]  data_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_byte,
    input logic        run_last,
    input logic        frame_end
);

    import dpf_pkg::*;

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(kind)
            && $stable(subtype_first) && $stable(subtype_second)
            && $stable(packet_total) && $stable(packet_number)
            && $stable(data_length) && $stable(data_byte))
        else $error("Stalled input transaction changed.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(run_last) && $stable(frame_end))
        else $error("Stalled output transaction changed.");

    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> run_last)
        else $error("Frame end without end of run.");

    a_frame_end_hex: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> is_hex_char(out_byte))
        else $error("Checksum digit is not a hex character.");

    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("Block not idle after reset.");

endmodule

bind data_packet_framer dpf_checker u_dpf_checker (.*);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import dpf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int USEFUL_ITEMS = 360;
    localparam int QUIET_TAIL = 40;
    localparam int HOLD_AFTER = 120;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic        kind;
        logic [7:0]  subtype_first;
        logic [7:0]  subtype_second;
        logic [15:0] packet_total;
        logic [15:0] packet_number;
        logic [15:0] data_length;
        logic [7:0]  data_byte;
    } framer_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } framed_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = KIND_HEADER;
    logic [7:0]  subtype_first = 8'h00;
    logic [7:0]  subtype_second = 8'h00;
    logic [15:0] packet_total = 16'h0000;
    logic [15:0] packet_number = 16'h0000;
    logic [15:0] data_length = 16'h0000;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        frame_end;

    framer_item_t pending_items[$];
    framed_byte_t expected_bytes[$];
    framer_item_t offered;
    framed_byte_t want;

    logic [15:0] pkt_remaining = 16'h0000;
    logic [7:0]  pkt_sum = 8'h00;
    logic        pkt_open = 1'b0;

    logic        gen_open = 1'b0;
    logic [15:0] gen_left = 16'h0000;
    int          useful_count = 0;
    int          header_count = 0;
    int          zero_len_count = 0;
    int          abandoned_count = 0;
    int          dropped_count = 0;

    int items_total = 0;
    int items_accepted = 0;
    int bytes_checked = 0;
    int frames_closed = 0;
    int error_count = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    data_packet_framer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .subtype_first (subtype_first),
        .subtype_second(subtype_second),
        .packet_total  (packet_total),
        .packet_number (packet_number),
        .data_length   (data_length),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .run_last      (run_last),
        .frame_end     (frame_end)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic logic [7:0] ascii_nibble(input logic [3:0] v);
        if (v < 4'd10)
        begin
            return 8'h30 + {4'h0, v};
        end
        return 8'h41 + {4'h0, v} - 8'd10;
    endfunction

    task automatic frame_item(input framer_item_t it);
        logic [7:0]  run_bytes [0:17];
        logic [15:0] shown_len;
        logic [7:0]  csum;
        logic        closes;
        int          n;
        closes = 1'b0;
        n = 0;
        if (it.kind == KIND_HEADER)
        begin
            shown_len = it.data_length + LENGTH_BIAS;
            run_bytes[0] = START_BYTE;
            run_bytes[1] = it.subtype_first;
            run_bytes[2] = it.subtype_second;
            run_bytes[3] = VERSION_BYTE;
            for (int i = 0; i < 4; i++)
            begin
                run_bytes[4 + i] = ascii_nibble(shown_len[15 - 4 * i -: 4]);
                run_bytes[8 + i] = ascii_nibble(it.packet_total[15 - 4 * i -: 4]);
                run_bytes[12 + i] = ascii_nibble(it.packet_number[15 - 4 * i -: 4]);
            end
            n = 16;
            pkt_sum = 8'h00;
            for (int i = 1; i < 16; i++)
            begin
                pkt_sum = pkt_sum + run_bytes[i];
            end
            pkt_remaining = it.data_length;
            pkt_open = 1'b1;
            closes = (it.data_length == 16'h0000);
        end
        else
        begin
            if (!pkt_open)
            begin
                return;
            end
            run_bytes[0] = it.data_byte;
            n = 1;
            pkt_sum = pkt_sum + it.data_byte;
            pkt_remaining = pkt_remaining - 16'd1;
            closes = (pkt_remaining == 16'h0000);
        end
        if (closes)
        begin
            csum = 8'h00 - pkt_sum;
            run_bytes[n] = ascii_nibble(csum[7:4]);
            run_bytes[n + 1] = ascii_nibble(csum[3:0]);
            n = n + 2;
            pkt_open = 1'b0;
            pkt_remaining = 16'h0000;
        end
        for (int i = 0; i < n; i++)
        begin
            expected_bytes.push_back({run_bytes[i], i == n - 1, closes && (i == n - 1)});
        end
    endtask

    task automatic add_header(input logic [7:0] s1, input logic [7:0] s2,
                              input logic [15:0] tot, input logic [15:0] num,
                              input logic [15:0] len);
        framer_item_t it;
        it.kind = KIND_HEADER;
        it.subtype_first = s1;
        it.subtype_second = s2;
        it.packet_total = tot;
        it.packet_number = num;
        it.data_length = len;
        it.data_byte = 8'($urandom_range(0, 255));
        pending_items.push_back(it);
        header_count++;
        useful_count++;
        if (gen_open)
        begin
            abandoned_count++;
        end
        gen_open = (len != 16'h0000);
        gen_left = len;
        if (len == 16'h0000)
        begin
            zero_len_count++;
        end
    endtask

    task automatic add_data(input logic [7:0] b);
        framer_item_t it;
        it.kind = KIND_DATA;
        it.subtype_first = 8'($urandom_range(0, 255));
        it.subtype_second = 8'($urandom_range(0, 255));
        it.packet_total = 16'($urandom_range(0, 65535));
        it.packet_number = 16'($urandom_range(0, 65535));
        it.data_length = 16'($urandom_range(0, 65535));
        it.data_byte = b;
        pending_items.push_back(it);
        if (!gen_open)
        begin
            dropped_count++;
        end
        else
        begin
            useful_count++;
            gen_left = gen_left - 16'd1;
            gen_open = (gen_left != 16'h0000);
        end
    endtask

    task automatic add_random_header(input logic [15:0] len);
        add_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), len);
    endtask

    task automatic build_stimulus();
        int pick;
        int len;
        int cut;
        add_data(8'hFF);
        add_header(8'h00, 8'h00, 16'h0000, 16'hFFFF, 16'd0);
        add_header(8'hFF, 8'hFF, 16'hFFFF, 16'h0000, 16'd0);
        add_header(8'h44, 8'h54, 16'h0001, 16'h0001, 16'd1);
        add_data(8'h00);
        add_header(8'h41, 8'h42, 16'h1234, 16'hABCD, 16'd2);
        add_data(8'hFF);
        add_data(8'hA5);
        add_data(8'h5A);
        add_header(8'h12, 8'h34, 16'h0002, 16'h0001, 16'd65527);
        add_data(8'h01);
        add_data(8'h02);
        add_header(8'h55, 8'hAA, 16'h5678, 16'h9ABC, 16'hFFF8);
        add_data(8'h7F);
        add_header(8'hAA, 8'h55, 16'hDEF0, 16'h0FED, 16'hFFFF);
        add_header(8'h80, 8'h7F, 16'h0003, 16'h0002, 16'd3);
        add_data(8'h80);
        add_data(8'h81);
        add_data(8'h82);
        add_data(8'h10);
        while (useful_count < USEFUL_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 5);
                add_random_header(16'(len));
                for (int i = 0; i < len; i++)
                begin
                    add_data(8'($urandom_range(0, 255)));
                end
            end
            else if (pick < 86)
            begin
                add_random_header(16'($urandom_range(0, 65535)));
                cut = $urandom_range(0, 3);
                for (int i = 0; i < cut; i++)
                begin
                    add_data(8'($urandom_range(0, 255)));
                end
            end
            else if (pick < 93)
            begin
                add_data(8'($urandom_range(0, 255)));
            end
            else
            begin
                len = $urandom_range(3, 10);
                add_random_header(16'(len));
                cut = $urandom_range(1, len - 1);
                for (int i = 0; i < cut; i++)
                begin
                    add_data(8'($urandom_range(0, 255)));
                end
            end
        end
        items_total = pending_items.size();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                frame_item(offered);
                items_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() >= QUIET_TAIL && hold_left == 0
                         && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(0, 11);
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    offered = pending_items.pop_front();
                    in_valid <= 1'b1;
                    kind <= offered.kind;
                    subtype_first <= offered.subtype_first;
                    subtype_second <= offered.subtype_second;
                    packet_total <= offered.packet_total;
                    packet_number <= offered.packet_number;
                    data_length <= offered.data_length;
                    data_byte <= offered.data_byte;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // The long hold lets the block fill up while transactions keep arriving.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && items_accepted >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (pending_items.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 11);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected byte %02h (run_last %b, frame_end %b)",
                         $time, out_byte, run_last, frame_end);
            end
            else
            begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (frame_end)
                begin
                    frames_closed++;
                end
                if (out_byte !== want.out_byte)
                begin
                    error_count++;
                    $display("%0t: out_byte expected %02h, actual %02h",
                             $time, want.out_byte, out_byte);
                end
                if (run_last !== want.run_last)
                begin
                    error_count++;
                    $display("%0t: run_last expected %b, actual %b",
                             $time, want.run_last, run_last);
                end
                if (frame_end !== want.frame_end)
                begin
                    error_count++;
                    $display("%0t: frame_end expected %b, actual %b",
                             $time, want.frame_end, frame_end);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("Timed out after %0d cycles with %0d of %0d transactions accepted.",
                 cycle_count, items_accepted, items_total);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        build_stimulus();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        while (items_accepted < items_total)
        begin
            @(posedge clk);
        end
        while (expected_bytes.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        $display("Sent %0d transactions: %0d headers (%0d zero-length, %0d abandoned), %0d %s",
                 items_total, header_count, zero_len_count, abandoned_count, dropped_count,
                 "stray data.");
        $display("Checked %0d output bytes and %0d closed frames, %0d mismatches.",
                 bytes_checked, frames_closed, error_count);
        if (error_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/dpf_pkg.sv
sv/data_packet_framer.sv
sv/dpf_checker.sv
verif/tb_top.sv
